>>> rtl/teq_pkg.sv
// Shared types and constants for the timed event priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package teq_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int TIME_W   = 31;
    localparam int KIND_W   = 8;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Action codes carried on the input channel.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]        ev_time;
        logic [KIND_W-1:0]        ev_kind;
        logic signed [WORD_W-1:0] ev_first;
        logic signed [WORD_W-1:0] ev_second;
    } t_event;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> rtl/timed_event_priority_queue_unit.sv
// Top level of the timed event priority queue: controller plus datapath.
// Depends on teq_pkg, teq_ctrl and teq_dp.
//
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is
//   low. i_action selects insert (event fields are stored in time order) or
//   remove (the earliest event is returned). Events with equal times leave
//   in the order they were inserted.
//   Each transaction yields one result, shown for exactly one cycle with
//   o_result_valid high in the report state, which follows the execute
//   state. busy stays high from acceptance through the result cycle; the
//   state machine handles one at a time and each insert or remove is done
//   by the cell row by compare and shift in the execute state.
//   An insert into a full store is dropped with status full; a remove from
//   an empty store reports status empty. Removed-event fields are zero
//   whenever no event was removed.
//   Reset (i_rst_n low, synchronous) empties the store and returns to idle;
//   no clearing pass is needed. The receiver cannot stall the result.
`default_nettype none

module timed_event_priority_queue_unit #(
    parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_action,
    input  wire logic [teq_pkg::TIME_W-1:0]         i_event_time,
    input  wire logic [teq_pkg::KIND_W-1:0]         i_event_kind,
    input  wire logic signed [teq_pkg::WORD_W-1:0]  i_data_first,
    input  wire logic signed [teq_pkg::WORD_W-1:0]  i_data_second,
    output logic                                    o_result_valid,
    output logic [teq_pkg::STATUS_W-1:0]            o_status,
    output logic [teq_pkg::TIME_W-1:0]              o_out_time,
    output logic [teq_pkg::KIND_W-1:0]              o_out_kind,
    output logic signed [teq_pkg::WORD_W-1:0]       o_out_data_first,
    output logic signed [teq_pkg::WORD_W-1:0]       o_out_data_second,
    output logic [teq_pkg::COUNT_W-1:0]             o_stored_count,
    output logic                                    o_is_empty
);
    import teq_pkg::*;

    t_dp_cmd cmd;

    teq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (cmd)
    );

    teq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_action          (i_action),
        .i_event_time      (i_event_time),
        .i_event_kind      (i_event_kind),
        .i_data_first      (i_data_first),
        .i_data_second     (i_data_second),
        .o_status          (o_status),
        .o_out_time        (o_out_time),
        .o_out_kind        (o_out_kind),
        .o_out_data_first  (o_out_data_first),
        .o_out_data_second (o_out_data_second),
        .o_stored_count    (o_stored_count),
        .o_is_empty        (o_is_empty)
    );

    // An accepted transaction reports its result once the execute state has passed.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("result strobe missing two cycles after acceptance");

    // A remove from an empty store leaves the store empty.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_EMPTY)) |-> o_is_empty)
        else $error("empty status reported with events still stored");

    // A dropped insert means the store is full, hence not empty.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_FULL)) |-> !o_is_empty)
        else $error("full status reported on an empty store");

    // Failed transactions carry no removed event.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != ST_OK)) |->
        ((o_out_time == '0) && (o_out_kind == '0) &&
         (o_out_data_first == '0) && (o_out_data_second == '0)))
        else $error("removed-event fields not zero on a failed transaction");

endmodule

`default_nettype wire

>>> rtl/teq_ctrl.sv
// Controller state machine of the timed event priority queue.
// Depends on teq_pkg; drives the datapath through a t_dp_cmd struct.
`default_nettype none

module teq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    output logic                  o_result_valid,
    output teq_pkg::t_dp_cmd      o_cmd
);
    import teq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:   n_state = S_REPORT;
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy           = 1'b1;
        o_result_valid = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.exec     = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_REPORT: begin
                o_result_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/teq_dp.sv
// Datapath of the timed event priority queue: a sorted row of event cells
// with compare-and-shift logic, the occupancy counter and the result registers.
// Depends on teq_pkg.
`default_nettype none

module teq_dp #(
    parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire teq_pkg::t_dp_cmd                   i_cmd,
    input  wire logic                               i_action,
    input  wire logic [teq_pkg::TIME_W-1:0]         i_event_time,
    input  wire logic [teq_pkg::KIND_W-1:0]         i_event_kind,
    input  wire logic signed [teq_pkg::WORD_W-1:0]  i_data_first,
    input  wire logic signed [teq_pkg::WORD_W-1:0]  i_data_second,
    output logic [teq_pkg::STATUS_W-1:0]            o_status,
    output logic [teq_pkg::TIME_W-1:0]              o_out_time,
    output logic [teq_pkg::KIND_W-1:0]              o_out_kind,
    output logic signed [teq_pkg::WORD_W-1:0]       o_out_data_first,
    output logic signed [teq_pkg::WORD_W-1:0]       o_out_data_second,
    output logic [teq_pkg::COUNT_W-1:0]             o_stored_count,
    output logic                                    o_is_empty
);
    import teq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // Latched transaction.
    logic   r_action;
    t_event r_new;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    t_event r_cell [DEPTH];
    t_event n_cell [DEPTH];

    // A cell is "after" the new event when it is free or its time is strictly
    // later; ties stay ahead so equal times leave in arrival order.
    logic [DEPTH-1:0] after_new;

    logic    full;
    logic    empty;
    logic    do_insert;
    logic    do_remove;
    t_status n_status;
    t_event  n_out;

    logic [CW+COUNT_W-1:0] count_ext;

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign do_insert = (r_action == ACT_INSERT) && !full;
    assign do_remove = (r_action == ACT_REMOVE) && !empty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action          <= i_action;
            r_new.ev_time     <= i_event_time;
            r_new.ev_kind     <= i_event_kind;
            r_new.ev_first    <= i_data_first;
            r_new.ev_second   <= i_data_second;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign after_new[gi] = (CW'(gi) >= r_count) ||
                                   (r_cell[gi].ev_time > r_new.ev_time);

            if (gi == 0) begin : g_head
                always_comb begin
                    n_cell[gi] = r_cell[gi];
                    if (do_insert && after_new[gi]) begin
                        n_cell[gi] = r_new;
                    end else if (do_remove) begin
                        if (DEPTH > 1) begin
                            n_cell[gi] = r_cell[(gi + 1) % DEPTH];
                        end
                    end
                end
            end else begin : g_body
                always_comb begin
                    n_cell[gi] = r_cell[gi];
                    if (do_insert && after_new[gi]) begin
                        n_cell[gi] = after_new[gi-1] ? r_cell[gi-1] : r_new;
                    end else if (do_remove && (gi < DEPTH - 1)) begin
                        n_cell[gi] = r_cell[(gi + 1) % DEPTH];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    r_cell[gi] <= n_cell[gi];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_out    = '0;
        if (r_action == ACT_INSERT) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_out   = r_cell[0];
                n_count = r_count - CW'(1);
            end
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_status          <= n_status;
            o_out_time        <= n_out.ev_time;
            o_out_kind        <= n_out.ev_kind;
            o_out_data_first  <= n_out.ev_first;
            o_out_data_second <= n_out.ev_second;
            o_stored_count    <= count_ext[COUNT_W-1:0];
            o_is_empty        <= (n_count == '0);
        end
    end

endmodule

`default_nettype wire

>>> test/timed_event_queue_checker.sv
// Checker for the timed event priority queue: watches the command and result
// channels, keeps its own sorted event list, and compares every result.
// Depends on teq_pkg.
`timescale 1ns / 1ps

module timed_event_queue_checker #(
    parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              i_action,
    input  logic [teq_pkg::TIME_W-1:0]        i_event_time,
    input  logic [teq_pkg::KIND_W-1:0]        i_event_kind,
    input  logic signed [teq_pkg::WORD_W-1:0] i_data_first,
    input  logic signed [teq_pkg::WORD_W-1:0] i_data_second,
    input  logic                              o_result_valid,
    input  logic [teq_pkg::STATUS_W-1:0]      o_status,
    input  logic [teq_pkg::TIME_W-1:0]        o_out_time,
    input  logic [teq_pkg::KIND_W-1:0]        o_out_kind,
    input  logic signed [teq_pkg::WORD_W-1:0] o_out_data_first,
    input  logic signed [teq_pkg::WORD_W-1:0] o_out_data_second,
    input  logic [teq_pkg::COUNT_W-1:0]       o_stored_count,
    input  logic                              o_is_empty,
    output int                                fail_count,
    output int                                pending_results,
    output int                                results_checked,
    output int                                full_drops,
    output int                                empty_removes
);
    import teq_pkg::*;

    typedef struct packed {
        t_status            status;
        t_event             removed;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } t_queue_result;

    t_event        future_events[$];
    t_queue_result expected_results[$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        results_checked = 0;
        full_drops      = 0;
        empty_removes   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Every field fits in one data word, so no sign extension takes place.
    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Applies one command to the sorted event list and returns the result it
    // must produce. Ties in time keep insertion order, so a new event goes
    // after every stored event whose time is not later.
    function automatic t_queue_result apply_event_command(input logic action,
                                                          input t_event ev);
        t_queue_result res;
        int            pos;
        res = '0;
        res.status = ST_OK;
        if (action == ACT_INSERT) begin
            if (future_events.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < future_events.size() && future_events[pos].ev_time <= ev.ev_time)
                    pos++;
                future_events.insert(pos, ev);
            end
        end else begin
            if (future_events.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed = future_events.pop_front();
            end
        end
        res.count = COUNT_W'(future_events.size());
        res.empty = (future_events.size() == 0);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result want;
        t_event        ev;
        if (!i_rst_n) begin
            future_events.delete();
            expected_results.delete();
        end else begin
            if (o_result_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no command outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", WORD_W'(o_status), WORD_W'(want.status));
                    check_field("out_time", WORD_W'(o_out_time),
                                WORD_W'(want.removed.ev_time));
                    check_field("out_kind", WORD_W'(o_out_kind),
                                WORD_W'(want.removed.ev_kind));
                    check_field("out_data_first", o_out_data_first, want.removed.ev_first);
                    check_field("out_data_second", o_out_data_second,
                                want.removed.ev_second);
                    check_field("stored_count", WORD_W'(o_stored_count),
                                WORD_W'(want.count));
                    check_field("is_empty", WORD_W'(o_is_empty), WORD_W'(want.empty));
                    results_checked++;
                end
            end
            if (start && !busy) begin
                ev.ev_time   = i_event_time;
                ev.ev_kind   = i_event_kind;
                ev.ev_first  = i_data_first;
                ev.ev_second = i_data_second;
                want = apply_event_command(i_action, ev);
                if (want.status == ST_FULL)
                    full_drops++;
                if (want.status == ST_EMPTY)
                    empty_removes++;
                expected_results.push_back(want);
            end
        end
        pending_results <= expected_results.size();
    end

endmodule

>>> test/timed_event_priority_queue_unit_tb.sv
// Testbench top for the timed event priority queue: clock, reset, command
// stimulus with bursty pacing, and the verdict. Depends on teq_pkg, the
// block timed_event_priority_queue_unit and timed_event_queue_checker.
`timescale 1ns / 1ps

module timed_event_priority_queue_unit_tb;
    import teq_pkg::*;

    localparam int RANDOM_COMMANDS = 750;
    localparam int CYCLE_LIMIT     = 200000;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_action;
    logic [TIME_W-1:0]        i_event_time;
    logic [KIND_W-1:0]        i_event_kind;
    logic signed [WORD_W-1:0] i_data_first;
    logic signed [WORD_W-1:0] i_data_second;
    logic                     o_result_valid;
    logic [STATUS_W-1:0]      o_status;
    logic [TIME_W-1:0]        o_out_time;
    logic [KIND_W-1:0]        o_out_kind;
    logic signed [WORD_W-1:0] o_out_data_first;
    logic signed [WORD_W-1:0] o_out_data_second;
    logic [COUNT_W-1:0]       o_stored_count;
    logic                     o_is_empty;

    int fail_count;
    int pending_results;
    int results_checked;
    int full_drops;
    int empty_removes;
    int commands_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    always #2 i_clk = ~i_clk;

    timed_event_priority_queue_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_event_time      (i_event_time),
        .i_event_kind      (i_event_kind),
        .i_data_first      (i_data_first),
        .i_data_second     (i_data_second),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_out_time        (o_out_time),
        .o_out_kind        (o_out_kind),
        .o_out_data_first  (o_out_data_first),
        .o_out_data_second (o_out_data_second),
        .o_stored_count    (o_stored_count),
        .o_is_empty        (o_is_empty)
    );

    timed_event_queue_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_event_time      (i_event_time),
        .i_event_kind      (i_event_kind),
        .i_data_first      (i_data_first),
        .i_data_second     (i_data_second),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_out_time        (o_out_time),
        .o_out_kind        (o_out_kind),
        .o_out_data_first  (o_out_data_first),
        .o_out_data_second (o_out_data_second),
        .o_stored_count    (o_stored_count),
        .o_is_empty        (o_is_empty),
        .fail_count        (fail_count),
        .pending_results   (pending_results),
        .results_checked   (results_checked),
        .full_drops        (full_drops),
        .empty_removes     (empty_removes)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Holds start high until the block takes the transaction.
    task automatic issue_command(input logic action, input logic [TIME_W-1:0] t,
                                 input logic [KIND_W-1:0] k,
                                 input logic [WORD_W-1:0] d1,
                                 input logic [WORD_W-1:0] d2);
        start         <= 1'b1;
        i_action      <= action;
        i_event_time  <= t;
        i_event_kind  <= k;
        i_data_first  <= d1;
        i_data_second <= d2;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        commands_sent++;
    endtask

    // Bursts of back-to-back commands separated by idle gaps; a long burst
    // now and then gives stretches with no idling at all.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    // Small time ranges give many ties; the rest covers a wider range, full-field values and both extremes.
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return TIME_W'($urandom_range(0, 31));
            5, 6:          return TIME_W'($urandom_range(0, 1000));
            7:             return TIME_W'($urandom);
            8:             return '0;
            default:       return TIME_MAX;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_insert(input logic [TIME_W-1:0] t, input logic [KIND_W-1:0] k,
                               input logic [WORD_W-1:0] d1, input logic [WORD_W-1:0] d2);
        issue_command(ACT_INSERT, t, k, d1, d2);
        pace_sender();
    endtask

    // The event fields of a remove are ignored, so they carry noise.
    task automatic send_remove();
        issue_command(ACT_REMOVE, TIME_W'($urandom), KIND_W'($urandom), $urandom, $urandom);
        pace_sender();
    endtask

    initial begin
        int insert_pct;
        int segment_left;
        int random_sent;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_action      <= ACT_INSERT;
        i_event_time  <= '0;
        i_event_kind  <= '0;
        i_data_first  <= '0;
        i_data_second <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: removal from an empty store, field extremes, and a group
        // of equal times that must leave in arrival order.
        send_remove();
        send_insert(TIME_MAX, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_insert('0, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF);
        send_insert(TIME_W'(100), 8'h11, 32'h0000_0001, 32'hFFFF_FFFF);
        send_insert(TIME_W'(100), 8'h22, 32'h0000_0002, 32'hFFFF_FFFE);
        send_insert(TIME_W'(100), 8'h33, 32'h0000_0003, 32'hFFFF_FFFD);
        send_insert(TIME_W'(50), 8'hA5, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_insert(TIME_MAX, 8'h01, 32'h0000_0000, 32'hFFFF_FFFF);
        repeat (8) send_remove();
        send_insert(TIME_W'(7), 8'h80, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_remove();
        send_remove();

        // Random: segments that lean toward filling, draining or neither.
        // The first segment overfills the store to exercise dropped inserts.
        random_sent  = 0;
        insert_pct   = 100;
        segment_left = DEPTH_DEFAULT + 6;
        while (random_sent < RANDOM_COMMANDS) begin
            if (segment_left == 0) begin
                case ($urandom_range(0, 4))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    2:       insert_pct = 100;
                    3:       insert_pct = 0;
                    default: insert_pct = 50;
                endcase
                segment_left = (insert_pct == 100 || insert_pct == 0) ?
                               $urandom_range(DEPTH_DEFAULT, DEPTH_DEFAULT + 8) :
                               $urandom_range(20, 120);
            end
            if ($urandom_range(0, 99) < insert_pct)
                send_insert(pick_time(), KIND_W'($urandom_range(0, 255)), pick_word(),
                            pick_word());
            else
                send_remove();
            segment_left--;
            random_sent++;
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d results.", commands_sent,
                 results_checked);
        $display("Covered %0d inserts dropped on a full store and %0d removes from empty.",
                 full_drops, empty_removes);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
